// ----- rtl/ffpra_pkg.sv -----
// Shared types and codes for the first-fit page-run allocator.
// Depends on nothing; the cell, the controller and the top level import it.
`default_nettype none

package ffpra_pkg;

	// Width of page indexes and range bounds; covers maps of up to 1024 pages
	// and the sum of an 8-bit offset and an 8-bit count.
	localparam int unsigned RANGE_W = 11;

	localparam int unsigned DEFAULT_PAGES = 128;

	// Request types.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Response status codes.
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_NOROOM = 2'd1;
	localparam logic [1:0] STAT_BAD    = 2'd2;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic               set;
		logic               clr;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		logic [7:0]         count;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_page_run_allocator.sv -----
// Top level of the first-fit page-run allocator: the chain of page cells and
// the request sequencer. Depends on ffpra_pkg, ffpra_cell and ffpra_ctrl.
`default_nettype none

// The allocator keeps one used bit per page in a row of PAGES cells, all pages
// free after reset. An allocate request launches a search token into the first
// cell; the token moves one cell along the row each clock, carrying how many
// more free pages the current run still needs, and restarts that figure at the
// full count whenever it meets a used page. The first cell at which the run
// completes reports it, and the block marks that run used in a single
// broadcast cycle and answers with the run's first index plus one. If the
// token walks off the end of the row, the answer is "no room" and nothing
// changes. A free request clears its range in one broadcast cycle. A count of
// zero, an allocate larger than the map, a free with an offset of zero and a
// free that reaches beyond the map are answered as bad requests without
// touching the map. One request is handled at a time: an allocate waits while
// the token walks the row, then passes through the broadcast when a run is
// found and has its result loaded into the output register; a free passes
// through its broadcast before its result is loaded, and a bad request has its
// result loaded directly. A finished result sits in an output register, so the
// next item can be accepted while it waits to be taken.
module first_fit_page_run_allocator #(
	parameter int unsigned PAGES = ffpra_pkg::DEFAULT_PAGES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic       req_type,
	input  wire logic [7:0] page_count,
	input  wire logic [7:0] page_offset,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [1:0]      status,
	output logic [7:0]      start_page
);
	import ffpra_pkg::*;

	cell_cmd_t        cmd;
	logic             inject;
	logic [PAGES:0]   tok_link;
	logic [7:0]       need_link [PAGES+1];
	logic [PAGES-1:0] found_vec;
	logic [PAGES-1:0] busy_vec;
	logic             found_any;
	logic             tok_exit;

	assign tok_link[0]  = inject;
	assign need_link[0] = page_count;
	assign found_any    = |found_vec;
	assign tok_exit     = tok_link[PAGES];

	ffpra_ctrl #(
		.PAGES(PAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.page_count (page_count),
		.page_offset(page_offset),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.start_page (start_page),
		.cmd        (cmd),
		.inject     (inject),
		.found_any  (found_any),
		.tok_exit   (tok_exit)
	);

	// The row of page cells; each hands the search token to its right-hand
	// neighbour.
	for (genvar i = 0; i < PAGES; i++) begin : g_cell
		ffpra_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok_link[i]),
			.need_in (need_link[i]),
			.tok_out (tok_link[i+1]),
			.need_out(need_link[i+1]),
			.found   (found_vec[i]),
			.busy    (busy_vec[i])
		);
	end

	// There is never more than one search token in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(busy_vec))
		else $error("more than one search token in the cell row");

	// A run is never both found and lost off the end in the same cycle.
	a_found_or_exit: assert property (@(posedge clk) disable iff (!arst_n)
		!(found_any && tok_exit))
		else $error("run found and token left the row together");

	// A token leaving the row always still needs at least one page.
	a_exit_need: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit |-> (need_link[PAGES] != 8'd0))
		else $error("token left the row with nothing left to find");

	// A new request is only taken once the row holds no token.
	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (busy_vec == '0))
		else $error("request accepted while a search is in flight");

endmodule

`default_nettype wire

// ----- rtl/ffpra_cell.sv -----
// One page of the allocator chain: its used bit and the search token stage.
// Depends on ffpra_pkg.
`default_nettype none

module ffpra_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ffpra_pkg::cell_cmd_t  cmd,
	input  wire logic                  tok_in,
	input  wire logic [7:0]            need_in,
	output logic                       tok_out,
	output logic [7:0]                 need_out,
	output logic                       found,
	output logic                       busy
);
	import ffpra_pkg::*;

	localparam logic [RANGE_W-1:0] MY_IDX = RANGE_W'(IDX);

	logic       used_q;
	logic       tok_q;
	logic [7:0] need_q;
	logic       in_range;

	assign in_range = (MY_IDX >= cmd.lo) && (MY_IDX <= cmd.hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (cmd.set && in_range) begin
				used_q <= 1'b1;
			end else if (cmd.clr && in_range) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		need_q <= need_in;
	end

	// A used page restarts the run; a free page either completes it or
	// passes on one page fewer still needed.
	assign found    = tok_q && !used_q && (need_q == 8'd1);
	assign tok_out  = tok_q && (used_q || (need_q != 8'd1));
	assign need_out = used_q ? cmd.count : (need_q - 8'd1);
	assign busy     = tok_q;

endmodule

`default_nettype wire

// ----- rtl/ffpra_ctrl.sv -----
// Request sequencer of the allocator: checks requests, launches the search,
// broadcasts range updates to the chain and holds the response register.
// Depends on ffpra_pkg.
`default_nettype none

module ffpra_ctrl #(
	parameter int unsigned PAGES = ffpra_pkg::DEFAULT_PAGES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  req_type,
	input  wire logic [7:0]            page_count,
	input  wire logic [7:0]            page_offset,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic [1:0]                 status,
	output logic [7:0]                 start_page,
	output ffpra_pkg::cell_cmd_t       cmd,
	output logic                       inject,
	input  wire logic                  found_any,
	input  wire logic                  tok_exit
);
	import ffpra_pkg::*;

	localparam int unsigned IW = $clog2(PAGES);
	localparam logic [RANGE_W-1:0] PAGES_W = RANGE_W'(PAGES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_REPLY = 2'd3;

	logic [1:0]         state_q;
	logic               rsp_valid_q;
	logic [1:0]         status_q;
	logic [7:0]         start_page_q;
	logic               op_set_q;
	logic [RANGE_W-1:0] lo_q;
	logic [RANGE_W-1:0] hi_q;
	logic [7:0]         count_q;
	logic [IW-1:0]      pos_q;
	logic [1:0]         res_status_q;
	logic [7:0]         res_start_q;

	logic               accept;
	logic               load_rsp;
	logic [RANGE_W-1:0] cnt_w;
	logic [RANGE_W-1:0] off_w;
	logic [RANGE_W-1:0] free_first;
	logic [RANGE_W-1:0] free_last;
	logic               alloc_bad;
	logic               free_bad;
	logic               req_bad;
	logic [RANGE_W-1:0] pos_w;
	logic [RANGE_W-1:0] fit_first;
	logic [RANGE_W-1:0] fit_offset;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_rsp  = (state_q == ST_REPLY) && (!rsp_valid_q || rsp_ready);

	assign cnt_w      = RANGE_W'(page_count);
	assign off_w      = RANGE_W'(page_offset);
	assign free_first = off_w - RANGE_W'(1);
	assign free_last  = off_w + cnt_w - RANGE_W'(2);
	assign alloc_bad  = (page_count == 8'd0) || (cnt_w > PAGES_W);
	assign free_bad   = (page_count == 8'd0) || (page_offset == 8'd0) ||
	                    ((free_first + cnt_w) > PAGES_W);
	assign req_bad    = (req_type == REQ_ALLOC) ? alloc_bad : free_bad;

	assign pos_w      = RANGE_W'(pos_q);
	assign fit_first  = pos_w + RANGE_W'(1) - RANGE_W'(count_q);
	assign fit_offset = fit_first + RANGE_W'(1);

	assign inject = accept && (req_type == REQ_ALLOC) && !alloc_bad;

	assign cmd.set   = (state_q == ST_APPLY) && op_set_q;
	assign cmd.clr   = (state_q == ST_APPLY) && !op_set_q;
	assign cmd.lo    = lo_q;
	assign cmd.hi    = hi_q;
	assign cmd.count = count_q;

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign start_page = start_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_bad) begin
							state_q <= ST_REPLY;
						end else if (req_type == REQ_ALLOC) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_SCAN: begin
					if (found_any) begin
						state_q <= ST_APPLY;
					end else if (tok_exit) begin
						state_q <= ST_REPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q      <= page_count;
			op_set_q     <= (req_type == REQ_ALLOC);
			lo_q         <= free_first;
			hi_q         <= free_last;
			pos_q        <= '0;
			res_status_q <= req_bad ? STAT_BAD : STAT_DONE;
			res_start_q  <= 8'd0;
		end else if (state_q == ST_SCAN) begin
			pos_q <= pos_q + IW'(1);
			if (found_any) begin
				lo_q         <= fit_first;
				hi_q         <= pos_w;
				res_status_q <= STAT_DONE;
				res_start_q  <= fit_offset[7:0];
			end else if (tok_exit) begin
				res_status_q <= STAT_NOROOM;
				res_start_q  <= 8'd0;
			end
		end
		if (load_rsp) begin
			status_q     <= res_status_q;
			start_page_q <= res_start_q;
		end
	end

endmodule

`default_nettype wire
